// ===== design/sinc_interpolation_scatter_add_top_macros.svh =====
// assertion macros for the scatter-add gridding block
`ifndef SINC_INTERPOLATION_SCATTER_ADD_TOP_MACROS_SVH
`define SINC_INTERPOLATION_SCATTER_ADD_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, clocked on clk, held off while rst_n is low
`define SISA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, clocked on clk, held off while rst_n is low
`define SISA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SISA_ASSERT_IMP(lbl, ante, cons)
`define SISA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== design/sisa_pkg.sv =====
// package with types and constants of the scatter-add gridding block
package sisa_pkg;

    localparam int OVERSAMPLE_DEF = 16;
    localparam int TAPS_DEF       = 8;
    localparam int LINE_LEN_DEF   = 1024;

    localparam int POS_FB = 28;
    localparam logic [23:0] ISS_RESET = 24'd65536;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_ADD  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_POS,
        ST_PH,
        ST_CHK,
        ST_TAP,
        ST_DRAIN,
        ST_KWR,
        ST_RD,
        ST_RDW,
        ST_FIN
    } state_t;

endpackage

// ===== design/sinc_interpolation_scatter_add_top.sv =====
// point add: states MUL, POS, PH, CHK, TAP, DRAIN and FIN, one tap per cycle on the line store port
// dropped point: MUL, POS, PH, CHK, FIN; sample read and clear: RD, RDW, FIN; kernel word load: KWR, FIN
// one item at a time; the next item is taken while a result waits in the output register
// reset is asynchronous, active low; then a clearing pass zeroes every word of the
// line store, during which no item is taken (register writes still land)
`include "sinc_interpolation_scatter_add_top_macros.svh"

module sinc_interpolation_scatter_add_top #(
    parameter int OVERSAMPLE = sisa_pkg::OVERSAMPLE_DEF,
    parameter int TAPS       = sisa_pkg::TAPS_DEF,
    parameter int LINE_LEN   = sisa_pkg::LINE_LEN_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [23:0]  cfg_wdata,   // inv_sample_spacing
    input  logic         s_tvalid,
    output logic         s_tready,
    // index, kernel_value, point_re, point_im, range_diff, zero fill
    input  logic [111:0] s_tdata,
    input  logic [1:0]   s_tuser,     // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,     // sample_re, sample_im
    output logic [0:0]   m_tuser      // status
);

    localparam int KD = OVERSAMPLE * TAPS + 1;
    localparam int KA = $clog2(KD);
    localparam int LA = $clog2(LINE_LEN);
    localparam int TC = $clog2(TAPS);
    localparam int FB = sisa_pkg::POS_FB;
    localparam logic signed [56:0] HALF_POS = 57'(LINE_LEN / 2) << FB;

    sisa_pkg::state_t state_reg, state_next;

    logic [23:0] iss_reg;
    logic [LA-1:0] clr_cnt_reg;
    logic [TC-1:0] tap_cnt_reg;
    logic t1_valid_reg, t2_valid_reg, out_valid_reg;

    logic [1:0] req_reg;
    logic [9:0] idx_reg;
    logic signed [17:0] kval_reg;
    logic signed [23:0] pre_reg, pim_reg;
    logic signed [31:0] rdiff_reg;

    logic signed [56:0] prod_reg, pos_reg;
    logic signed [29:0] near_reg;
    logic neg_reg;
    logic [7:0] q_reg;
    logic [KA-1:0] kaddr_reg;
    logic [LA-1:0] laddr_reg, t1_addr_reg, t2_addr_reg;
    logic signed [41:0] prod_re_reg, prod_im_reg;
    logic [95:0] acc_reg;
    logic [47:0] res_re_reg, res_im_reg;
    logic res_st_reg;
    logic [95:0] out_data_reg;
    logic out_st_reg;

    logic [95:0] line_mem [LINE_LEN];
    logic signed [17:0] kern_mem [KD];
    logic [95:0] line_rd_reg;
    logic signed [17:0] kern_rd_reg;

    logic accept;
    logic lwe, kwe, tap_issue, out_load, drop, rd_in_range;
    logic [LA-1:0] lwa, lra;
    logic [95:0] lwd;
    logic [31:0] idx_wide;
    logic [27:0] frac, mag;
    logic [35:0] mq;
    logic signed [30:0] first_s, last_s;
    logic [KA-1:0] phase;
    logic offset;
    logic [47:0] sum_re, sum_im;

    assign accept   = s_tvalid && s_tready;
    assign idx_wide = 32'(idx_reg);
    assign rd_in_range = idx_wide < 32'(LINE_LEN);

    // phase split from the registered position
    assign frac = pos_reg[FB-1:0];
    assign mag  = frac[FB-1] ? 28'(29'(29'd1 << FB) - {1'b0, frac}) : frac;
    assign mq   = 36'(mag) * 36'(OVERSAMPLE);

    assign offset  = neg_reg && (q_reg != 8'd0);
    assign phase   = offset ? KA'(OVERSAMPLE - int'(q_reg)) : KA'(q_reg);
    assign first_s = 31'(near_reg) - 31'(TAPS / 2) + {30'd0, offset};
    assign last_s  = first_s + 31'(TAPS - 1);
    assign drop    = first_s[30] || (last_s >= 31'(LINE_LEN));

    assign sum_re = acc_reg[47:0] + 48'(prod_re_reg);
    assign sum_im = acc_reg[95:48] + 48'(prod_im_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sisa_pkg::ST_CLEAR;
            iss_reg       <= sisa_pkg::ISS_RESET;
            clr_cnt_reg   <= '0;
            tap_cnt_reg   <= '0;
            t1_valid_reg  <= 1'b0;
            t2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                iss_reg <= cfg_wdata;
            end
            if (state_reg == sisa_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (tap_issue)
            begin
                tap_cnt_reg <= tap_cnt_reg + 1'b1;
            end
            else
            begin
                tap_cnt_reg <= '0;
            end
            t1_valid_reg <= tap_issue;
            t2_valid_reg <= t1_valid_reg;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        tap_issue  = 1'b0;
        out_load   = 1'b0;
        kwe        = 1'b0;
        lra        = laddr_reg;
        unique case (state_reg)
            sisa_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == LA'(LINE_LEN - 1))
                begin
                    state_next = sisa_pkg::ST_IDLE;
                end
            end
            sisa_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (s_tuser)
                        sisa_pkg::REQ_LOAD: state_next = sisa_pkg::ST_KWR;
                        sisa_pkg::REQ_ADD:  state_next = sisa_pkg::ST_MUL;
                        sisa_pkg::REQ_READ: state_next = sisa_pkg::ST_RD;
                        default:            state_next = sisa_pkg::ST_FIN;
                    endcase
                end
            end
            sisa_pkg::ST_MUL: state_next = sisa_pkg::ST_POS;
            sisa_pkg::ST_POS: state_next = sisa_pkg::ST_PH;
            sisa_pkg::ST_PH:  state_next = sisa_pkg::ST_CHK;
            sisa_pkg::ST_CHK:
            begin
                state_next = drop ? sisa_pkg::ST_FIN : sisa_pkg::ST_TAP;
            end
            sisa_pkg::ST_TAP:
            begin
                tap_issue = 1'b1;
                if (tap_cnt_reg == TC'(TAPS - 1))
                begin
                    state_next = sisa_pkg::ST_DRAIN;
                end
            end
            sisa_pkg::ST_DRAIN:
            begin
                if (!t1_valid_reg && !t2_valid_reg)
                begin
                    state_next = sisa_pkg::ST_FIN;
                end
            end
            sisa_pkg::ST_KWR:
            begin
                kwe        = idx_wide < 32'(KD);
                state_next = sisa_pkg::ST_FIN;
            end
            sisa_pkg::ST_RD:
            begin
                lra        = idx_wide[LA-1:0];
                state_next = sisa_pkg::ST_RDW;
            end
            sisa_pkg::ST_RDW: state_next = sisa_pkg::ST_FIN;
            sisa_pkg::ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = sisa_pkg::ST_IDLE;
                end
            end
            default: state_next = sisa_pkg::ST_CLEAR;
        endcase
    end

    // line store write port: tap write-back, clearing pass, read-and-clear
    always_comb
    begin
        lwe = 1'b0;
        lwa = t2_addr_reg;
        lwd = {sum_im, sum_re};
        if (t2_valid_reg)
        begin
            lwe = 1'b1;
        end
        else if (state_reg == sisa_pkg::ST_CLEAR)
        begin
            lwe = 1'b1;
            lwa = clr_cnt_reg;
            lwd = '0;
        end
        else if (state_reg == sisa_pkg::ST_RDW)
        begin
            lwe = rd_in_range;
            lwa = idx_wide[LA-1:0];
            lwd = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lwe)
        begin
            line_mem[lwa] <= lwd;
        end
    end

    always_ff @(posedge clk)
    begin
        line_rd_reg <= line_mem[lra];
    end

    always_ff @(posedge clk)
    begin
        if (kwe)
        begin
            kern_mem[idx_wide[KA-1:0]] <= kval_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kern_rd_reg <= kern_mem[kaddr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= s_tuser;
            idx_reg    <= s_tdata[9:0];
            kval_reg   <= s_tdata[27:10];
            pre_reg    <= s_tdata[51:28];
            pim_reg    <= s_tdata[75:52];
            rdiff_reg  <= s_tdata[107:76];
            res_re_reg <= '0;
            res_im_reg <= '0;
            res_st_reg <= 1'b0;
        end
        if (state_reg == sisa_pkg::ST_MUL)
        begin
            prod_reg <= rdiff_reg * $signed({1'b0, iss_reg});
        end
        if (state_reg == sisa_pkg::ST_POS)
        begin
            pos_reg <= prod_reg + HALF_POS;
        end
        if (state_reg == sisa_pkg::ST_PH)
        begin
            near_reg <= 30'(pos_reg >>> FB) + 30'(frac[FB-1]);
            neg_reg  <= !frac[FB-1];
            q_reg    <= mq[35:FB];
        end
        if (state_reg == sisa_pkg::ST_CHK)
        begin
            kaddr_reg  <= phase;
            laddr_reg  <= first_s[LA-1:0];
            res_st_reg <= drop;
        end
        if (tap_issue)
        begin
            kaddr_reg   <= kaddr_reg + KA'(OVERSAMPLE);
            laddr_reg   <= laddr_reg + 1'b1;
            t1_addr_reg <= laddr_reg;
        end
        if (t1_valid_reg)
        begin
            prod_re_reg <= pre_reg * kern_rd_reg;
            prod_im_reg <= pim_reg * kern_rd_reg;
            acc_reg     <= line_rd_reg;
            t2_addr_reg <= t1_addr_reg;
        end
        if (state_reg == sisa_pkg::ST_RDW && rd_in_range)
        begin
            res_re_reg <= line_rd_reg[47:0];
            res_im_reg <= line_rd_reg[95:48];
        end
        if (out_load)
        begin
            out_data_reg <= {res_im_reg, res_re_reg};
            out_st_reg   <= res_st_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_st_reg;

    // request kind of the item in flight, checked against kernel writes
    logic req_unused;
    assign req_unused = (req_reg == sisa_pkg::REQ_LOAD);

    `SISA_ASSERT_IMP(a_no_item_in_clear, state_reg == sisa_pkg::ST_CLEAR, !s_tready)
    `SISA_ASSERT_IMP(a_tap_write_in_point, t2_valid_reg,
        state_reg == sisa_pkg::ST_TAP || state_reg == sisa_pkg::ST_DRAIN)
    `SISA_ASSERT_NXT(a_tap_pipe_flow, t1_valid_reg, t2_valid_reg)
    `SISA_ASSERT_NXT(a_accept_leaves_idle, accept, state_reg != sisa_pkg::ST_IDLE)
    `SISA_ASSERT_IMP(a_kernel_load_kind, kwe, req_unused)

endmodule

// ===== tb/sinc_interpolation_scatter_add_top_tb.sv =====
// self-checking testbench for the scatter-add gridding block, with its own line-store predictor
module sinc_interpolation_scatter_add_top_tb;

    localparam int OVERSAMPLE = sisa_pkg::OVERSAMPLE_DEF;
    localparam int TAPS       = sisa_pkg::TAPS_DEF;
    localparam int LINE_LEN   = sisa_pkg::LINE_LEN_DEF;
    localparam int KDEPTH     = OVERSAMPLE * TAPS + 1;
    localparam int POS_FB     = sisa_pkg::POS_FB;

    localparam logic [23:0] ISS_RESET = sisa_pkg::ISS_RESET;

    localparam logic [1:0] REQ_LOAD  = sisa_pkg::REQ_LOAD;
    localparam logic [1:0] REQ_ADD   = sisa_pkg::REQ_ADD;
    localparam logic [1:0] REQ_READ  = sisa_pkg::REQ_READ;
    localparam logic [1:0] REQ_NONE  = 2'd3;
    localparam logic       STAT_OK   = 1'b0;
    localparam logic       STAT_DROP = 1'b1;

    localparam int GAP_MAX        = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 250;
    localparam int NUM_PHASES     = 6;
    localparam int DIR_ROWS       = 25;
    localparam int SETTLE_CYCLES  = TAPS + 8 + 8;
    localparam int WATCHDOG_LIMIT = 6000;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [9:0]          index;
        logic signed [17:0]  kernel_value;
        logic signed [23:0]  point_re;
        logic signed [23:0]  point_im;
        logic signed [31:0]  range_diff;
    } req_item_t;

    typedef struct packed {
        logic [47:0] sample_re;
        logic [47:0] sample_im;
        logic        status;
    } sample_res_t;

    typedef struct packed {
        req_item_t   it;
        bit          typed;
        sample_res_t res;
    } dir_row_t;

    localparam sample_res_t RES_ZERO = '{48'd0, 48'd0, STAT_OK};
    localparam sample_res_t RES_DROP = '{48'd0, 48'd0, STAT_DROP};

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic [23:0]   cfg_wdata = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [111:0]  s_tdata = '0;
    logic [1:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [95:0]   m_tdata;
    logic [0:0]    m_tuser;

    // predictor state
    logic signed [17:0] kern_tab [0:KDEPTH-1] = '{default: '0};
    logic [47:0]        line_re [0:LINE_LEN-1] = '{default: '0};
    logic [47:0]        line_im [0:LINE_LEN-1] = '{default: '0};
    logic [23:0]        spacing = ISS_RESET;
    int                 last_first = LINE_LEN / 2;

    sample_res_t pending_samples [$];
    dir_row_t    dir_tab [DIR_ROWS];

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit hold_req = 1'b0;

    int n_err = 0;
    int n_load = 0;
    int n_add = 0;
    int n_drop = 0;
    int n_read = 0;
    int n_read_nz = 0;
    int n_cfg = 0;
    int idle_cnt = 0;

    sample_res_t mon_got;
    sample_res_t mon_want;

    sinc_interpolation_scatter_add_top #(
        .OVERSAMPLE(OVERSAMPLE),
        .TAPS(TAPS),
        .LINE_LEN(LINE_LEN)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic sample_res_t grid_predict(input req_item_t it);
        sample_res_t res;
        longint pos;
        longint near;
        longint rem;
        longint ph;
        longint first;
        longint coef;
        int off;
        int s;
        res = RES_ZERO;
        off = 0;
        case (it.req_type)
            REQ_LOAD:
            begin
                n_load++;
                if (int'(it.index) < KDEPTH)
                    kern_tab[it.index] = it.kernel_value;
            end
            REQ_ADD:
            begin
                n_add++;
                pos = longint'(it.range_diff) * longint'(spacing)
                    + (longint'(LINE_LEN / 2) <<< POS_FB);
                near = (pos + (longint'(1) <<< (POS_FB - 1))) >>> POS_FB;
                rem = (near <<< POS_FB) - pos;
                // remainder truncated toward zero to a phase
                ph = (rem * OVERSAMPLE) / (longint'(1) <<< POS_FB);
                if (ph < 0)
                begin
                    ph += OVERSAMPLE;
                    off = 1;
                end
                first = near - TAPS / 2 + off;
                if (first < 0 || first + TAPS - 1 >= LINE_LEN)
                begin
                    res.status = STAT_DROP;
                    n_drop++;
                end
                else
                begin
                    last_first = int'(first);
                    for (int x = 0; x < TAPS; x++)
                    begin
                        coef = longint'(kern_tab[int'(ph) + x * OVERSAMPLE]);
                        s = int'(first) + x;
                        line_re[s] = line_re[s] + 48'(longint'(it.point_re) * coef);
                        line_im[s] = line_im[s] + 48'(longint'(it.point_im) * coef);
                    end
                end
            end
            REQ_READ:
            begin
                n_read++;
                if (int'(it.index) < LINE_LEN)
                begin
                    res.sample_re = line_re[it.index];
                    res.sample_im = line_im[it.index];
                    line_re[it.index] = '0;
                    line_im[it.index] = '0;
                    if (res.sample_re != '0 || res.sample_im != '0)
                        n_read_nz++;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic req_item_t random_request();
        req_item_t it;
        int sel;
        longint lim;
        it.req_type = REQ_NONE;
        it.index = 10'($urandom);
        it.kernel_value = 18'($urandom);
        it.point_re = 24'($urandom);
        it.point_im = 24'($urandom);
        it.range_diff = 32'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            it.req_type = REQ_ADD;
            // mostly positions that land inside the line
            if (sel < 44 && spacing != '0)
            begin
                lim = (longint'(LINE_LEN / 2 - TAPS / 2) <<< POS_FB) / longint'(spacing);
                if (lim > 64'sh7FFFFFFF)
                    lim = 64'sh7FFFFFFF;
                it.range_diff = 32'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
            end
        end
        else if (sel < 82)
        begin
            it.req_type = REQ_READ;
            if ($urandom_range(0, 1) == 1)
                it.index = 10'(last_first + $urandom_range(0, TAPS));
        end
        else if (sel < 96)
        begin
            it.req_type = REQ_LOAD;
            if ($urandom_range(0, 9) < 7)
                it.index = 10'($urandom_range(0, KDEPTH - 1));
        end
        return it;
    endfunction

    task automatic offer_request(input req_item_t it, input bit typed,
                                 input sample_res_t typed_res);
        int gap;
        sample_res_t pred;
        gap = tx_idle ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.req_type;
        s_tdata <= {4'd0, it.range_diff, it.point_im, it.point_re, it.kernel_value, it.index};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = grid_predict(it);
        pending_samples.push_back(typed ? typed_res : pred);
        @(negedge clk);
    endtask

    task automatic write_spacing(input logic [23:0] value);
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        spacing = value;
        n_cfg++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            mon_got.sample_re = m_tdata[47:0];
            mon_got.sample_im = m_tdata[95:48];
            mon_got.status = m_tuser[0];
            if (pending_samples.size() == 0)
            begin
                $error("result with no item outstanding: re %0d im %0d status %0d",
                       $signed(mon_got.sample_re), $signed(mon_got.sample_im), mon_got.status);
                n_err++;
            end
            else
            begin
                mon_want = pending_samples.pop_front();
                if (mon_got.sample_re !== mon_want.sample_re)
                begin
                    $error("sample_re: expected %0d, got %0d",
                           $signed(mon_want.sample_re), $signed(mon_got.sample_re));
                    n_err++;
                end
                if (mon_got.sample_im !== mon_want.sample_im)
                begin
                    $error("sample_im: expected %0d, got %0d",
                           $signed(mon_want.sample_im), $signed(mon_got.sample_im));
                    n_err++;
                end
                if (mon_got.status !== mon_want.status)
                begin
                    $error("status: expected %0d, got %0d", mon_want.status, mon_got.status);
                    n_err++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cnt <= 0;
        else if (idle_cnt == WATCHDOG_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("sinc_interpolation_scatter_add_top_tb: done, errors");
            $finish;
        end
        else
            idle_cnt <= idle_cnt + 1;
    end

    // result receiver
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                stall = rx_idle ? $urandom_range(0, GAP_MAX) : 0;
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        req_item_t it;
        logic [23:0] iss;
        dir_tab = '{
            '{'{REQ_READ, 10'd0, 18'sd0, 24'sd0, 24'sd0, 32'sd0}, 1'b1, RES_ZERO},
            '{'{REQ_READ, 10'd1023, 18'sd0, 24'sd0, 24'sd0, 32'sd0}, 1'b1, RES_ZERO},
            '{'{REQ_LOAD, 10'd0, 18'sh20000, 24'sd0, 24'sd0, 32'sd0}, 1'b1, RES_ZERO},
            '{'{REQ_LOAD, 10'd127, 18'sh1FFFF, 24'sd0, 24'sd0, 32'sd0}, 1'b1, RES_ZERO},
            '{'{REQ_LOAD, 10'd128, -18'sd1, 24'sd0, 24'sd0, 32'sd0}, 1'b1, RES_ZERO},
            // load beyond the table is ignored
            '{'{REQ_LOAD, 10'd1023, 18'sd12345, 24'sd0, 24'sd0, 32'sd0}, 1'b1, RES_ZERO},
            '{'{REQ_NONE, 10'd1023, -18'sd1, -24'sd1, -24'sd1, -32'sd1}, 1'b1, RES_ZERO},
            '{'{REQ_ADD, 10'd0, 18'sd0, 24'sh7FFFFF, 24'sh800000, 32'sd0}, 1'b0, RES_ZERO},
            '{'{REQ_READ, 10'd508, 18'sd0, 24'sd0, 24'sd0, 32'sd0}, 1'b0, RES_ZERO},
            // first tap on sample zero, last tap on the top sample
            '{'{REQ_ADD, 10'd0, 18'sd0, 24'sh800000, 24'sh7FFFFF, -32'sd2080768},
              1'b0, RES_ZERO},
            '{'{REQ_ADD, 10'd0, 18'sd0, 24'sd1, -24'sd1, 32'sd2080768}, 1'b0, RES_ZERO},
            '{'{REQ_ADD, 10'd0, 18'sd0, 24'sd5, 24'sd7, 32'sd2084864}, 1'b1, RES_DROP},
            '{'{REQ_ADD, 10'd0, 18'sd0, 24'sd5, 24'sd7, -32'sd2084864}, 1'b1, RES_DROP},
            '{'{REQ_ADD, 10'd0, 18'sd0, 24'sd9, 24'sd9, 32'sh7FFFFFFF}, 1'b1, RES_DROP},
            '{'{REQ_ADD, 10'd0, 18'sd0, 24'sd9, 24'sd9, 32'sh80000000}, 1'b1, RES_DROP},
            // negative phase shifts the taps up and out of the line
            '{'{REQ_ADD, 10'd0, 18'sd0, 24'sd3, 24'sd3, 32'sd2081792}, 1'b1, RES_DROP},
            '{'{REQ_ADD, 10'd0, 18'sd0, 24'sd1000, -24'sd3, 32'sd1024}, 1'b0, RES_ZERO},
            // exact half sample either side of centre
            '{'{REQ_ADD, 10'd0, 18'sd0, -24'sd77, 24'sd55, 32'sd2048}, 1'b0, RES_ZERO},
            '{'{REQ_ADD, 10'd0, 18'sd0, 24'sd123, 24'sd456, -32'sd2048}, 1'b0, RES_ZERO},
            // tiny remainders truncate to phase zero
            '{'{REQ_ADD, 10'd0, 18'sd0, 24'sd4096, -24'sd4096, 32'sd100}, 1'b0, RES_ZERO},
            '{'{REQ_ADD, 10'd0, 18'sd0, -24'sd31, 24'sd17, -32'sd100}, 1'b0, RES_ZERO},
            '{'{REQ_READ, 10'd0, 18'sd0, 24'sd0, 24'sd0, 32'sd0}, 1'b0, RES_ZERO},
            '{'{REQ_READ, 10'd1023, 18'sd0, 24'sd0, 24'sd0, 32'sd0}, 1'b0, RES_ZERO},
            '{'{REQ_READ, 10'd512, 18'sd0, 24'sd0, 24'sd0, 32'sd0}, 1'b0, RES_ZERO},
            // read clears the sample
            '{'{REQ_READ, 10'd512, 18'sd0, 24'sd0, 24'sd0, 32'sd0}, 1'b1, RES_ZERO}
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // whole kernel table before any point add
        for (int i = 0; i < KDEPTH; i++)
        begin
            it = random_request();
            it.req_type = REQ_LOAD;
            it.index = 10'(i);
            offer_request(it, 1'b0, RES_ZERO);
        end
        for (int i = 0; i < DIR_ROWS; i++)
            offer_request(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);
        s_tvalid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: iss = 24'hFFFFFF;
                1: iss = 24'd0;
                2: iss = 24'($urandom);
                3: iss = ISS_RESET;
                4: iss = 24'($urandom_range(1 << 12, 1 << 20));
                default: iss = 24'($urandom_range(1, 255));
            endcase
            write_spacing(iss);
            tx_idle = (p != 1 && p != 3);
            rx_idle = (p != 1);
            if (p == 3)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_request(random_request(), 1'b0, RES_ZERO);
            s_tvalid <= 1'b0;
        end

        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run: %0d kernel loads, %0d point adds (%0d dropped), %0d reads (%0d non-zero)",
                 n_load, n_add, n_drop, n_read, n_read_nz);
        $display("run: %0d spacing settings incl. zero and full scale, one long output stall",
                 n_cfg);
        if (n_err == 0)
            $display("sinc_interpolation_scatter_add_top_tb: done, clean");
        else
            $display("sinc_interpolation_scatter_add_top_tb: done, errors");
        $finish;
    end

endmodule
